// File: rtl/dtmf_pkg.sv
// shared types, keypad tables and the fixed-point sine function for the dtmf generator
`default_nettype none

package dtmf_pkg;

    typedef logic signed [31:0] sine_t;
    typedef logic signed [15:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    last;
    } dtmf_result_t;

    localparam int FIFO_DEPTH = 4;

    localparam logic [15:0] BURST_LEN_RESET = 16'd1920;
    localparam logic signed [46:0] AMPLITUDE = 47'sd16383;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [31:0] ROW_HZ [4] = '{32'd697, 32'd770, 32'd852, 32'd941};
    localparam logic [31:0] COL_HZ [4] = '{32'd1209, 32'd1336, 32'd1477, 32'd1633};

    // per key: row and column of the keypad grid
    localparam logic [1:0] KEY_ROW [16] = '{
        2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
        2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3
    };
    localparam logic [1:0] KEY_COL [16] = '{
        2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd2
    };

    // (2n)(2n+1) for taylor terms n = 1..7
    localparam logic [63:0] TAYLOR_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // sine of a 32-bit phase in q30, taylor series through x^15; elaboration only
    function automatic sine_t sine_q30(input logic [31:0] p);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        f;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        quad = p[31:30];
        r    = {34'd0, p[29:0]};
        f    = quad[0] ? (Q30_ONE - r) : r;
        x    = (f * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 0; n < 7; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        if (sum > $signed(Q30_ONE))
            sum = $signed(Q30_ONE);
        if (quad[1])
            sum = -sum;
        return sum[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/dtmf_tone_generator_unit.sv
// dtmf tone generator: phase accumulators, sine lookup, mixing and burst marking
//
// usage:
//   input channel (in_valid, in_stall, key, restart): each item asks for one
//   pcm sample of the tone for a keypad key; restart clears both phases and
//   the burst counter before that sample is made.
//   output channel (out_valid, out_stall, sample, last_of_burst): one item per
//   input item, in order; last_of_burst marks the final sample of a burst.
//   config channel (cfg_valid, cfg_ready, cfg_burst_length): burst length,
//   always ready; write only while no items are in flight. zero acts as one.
// timing:
//   a taken item passes the index multiply, table read and mix stages into
//   the queue; one item per cycle sustained while in_stall is low. phase and
//   burst counter update at acceptance, so items follow back to back.
//   a 4-entry result queue holds finished items; in_stall rises once 4 items
//   are taken but not yet delivered, so an output stall backs up into the
//   input after the queue fills.
// reset: phases and counter clear, burst length returns to 1920, queue empties.
`default_nettype none

module dtmf_tone_generator_unit
    import dtmf_pkg::*;
#(
    parameter int TONE_RATE        = 48000,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  key,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [15:0] sample,
    output logic             last_of_burst,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_burst_length
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [63:0] HALF_RATE = 64'(TONE_RATE / 2);
    localparam logic [63:0] RATE      = 64'(TONE_RATE);

    localparam logic [31:0] ROW_INC [4] = '{
        32'(((64'(ROW_HZ[0]) << 32) + HALF_RATE) / RATE),
        32'(((64'(ROW_HZ[1]) << 32) + HALF_RATE) / RATE),
        32'(((64'(ROW_HZ[2]) << 32) + HALF_RATE) / RATE),
        32'(((64'(ROW_HZ[3]) << 32) + HALF_RATE) / RATE)
    };
    localparam logic [31:0] COL_INC [4] = '{
        32'(((64'(COL_HZ[0]) << 32) + HALF_RATE) / RATE),
        32'(((64'(COL_HZ[1]) << 32) + HALF_RATE) / RATE),
        32'(((64'(COL_HZ[2]) << 32) + HALF_RATE) / RATE),
        32'(((64'(COL_HZ[3]) << 32) + HALF_RATE) / RATE)
    };

    localparam logic signed [46:0] TRUNC_BIAS = 47'sd1073741823;

    logic             in_acc;
    logic             out_acc;
    logic [31:0]      low_phase_reg;
    logic [31:0]      low_phase_next;
    logic [31:0]      high_phase_reg;
    logic [31:0]      high_phase_next;
    logic [15:0]      sample_count_reg;
    logic [15:0]      sample_count_next;
    logic [15:0]      burst_len_reg;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             v1_reg;
    logic             v2_reg;
    logic             last1_reg;
    logic             last2_reg;

    logic [31:0]      low_used;
    logic [31:0]      high_used;
    logic [15:0]      count_used;
    logic [15:0]      len_eff;
    logic [16:0]      count_inc;
    logic             last_now;

    sine_t               sine_lo;
    sine_t               sine_hi;
    logic signed [32:0]  mix_sum;
    logic signed [46:0]  mix_prod;
    logic signed [46:0]  mix_trunc;
    dtmf_result_t        res_in;
    dtmf_result_t        res_out;

    assign in_stall  = (inflight_reg >= CNT_W'(FIFO_DEPTH));
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    // restart clears state before this item's sample
    assign low_used   = restart ? '0 : low_phase_reg;
    assign high_used  = restart ? '0 : high_phase_reg;
    assign count_used = restart ? '0 : sample_count_reg;

    assign len_eff   = (burst_len_reg == '0) ? 16'd1 : burst_len_reg;
    assign count_inc = {1'b0, count_used} + 17'd1;
    assign last_now  = (count_inc >= {1'b0, len_eff});

    always_comb
    begin
        low_phase_next    = low_phase_reg;
        high_phase_next   = high_phase_reg;
        sample_count_next = sample_count_reg;
        if (in_acc)
        begin
            low_phase_next    = low_used + ROW_INC[KEY_ROW[key]];
            high_phase_next   = high_used + COL_INC[KEY_COL[key]];
            sample_count_next = last_now ? '0 : count_inc[15:0];
        end
    end

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
            inflight_next = inflight_reg + 1'b1;
        else if (out_acc && !in_acc)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_phase_reg    <= '0;
            high_phase_reg   <= '0;
            sample_count_reg <= '0;
            burst_len_reg    <= BURST_LEN_RESET;
            inflight_reg     <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
        end
        else
        begin
            low_phase_reg    <= low_phase_next;
            high_phase_reg   <= high_phase_next;
            sample_count_reg <= sample_count_next;
            inflight_reg     <= inflight_next;
            v1_reg           <= in_acc;
            v2_reg           <= v1_reg;
            if (cfg_valid && cfg_ready)
                burst_len_reg <= cfg_burst_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            last1_reg <= last_now;
        last2_reg <= last1_reg;
    end

    dtmf_sine_lookup #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_lookup (
        .clk      (clk),
        .load     (in_acc),
        .phase_lo (low_used),
        .phase_hi (high_used),
        .sine_lo  (sine_lo),
        .sine_hi  (sine_hi)
    );

    // (lo + hi) * 16383 / 2^30, truncated toward zero
    assign mix_sum   = 33'(sine_lo) + 33'(sine_hi);
    assign mix_prod  = 47'(mix_sum) * AMPLITUDE;
    assign mix_trunc = mix_prod + (mix_prod[46] ? TRUNC_BIAS : 47'sd0);

    assign res_in.sample = mix_trunc[45:30];
    assign res_in.last   = last2_reg;

    dtmf_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (v2_reg),
        .push_data  (res_in),
        .pop        (out_acc),
        .head_valid (out_valid),
        .head_data  (res_out)
    );

    assign sample        = res_out.sample;
    assign last_of_burst = res_out.last;

`ifndef ASSERT_OFF
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(FIFO_DEPTH))
        else $error("items in flight exceed queue depth");

    a_out_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result shown with no item in flight");

    a_pipe_counted: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> inflight_reg != '0)
        else $error("pipeline item not counted in flight");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && restart |=> sample_count_reg <= 16'd1)
        else $error("burst counter not cleared by restart");
`endif

endmodule

`default_nettype wire

// File: rtl/dtmf_sine_lookup.sv
// phase to table index and registered two-port sine table read
`default_nettype none

module dtmf_sine_lookup
    import dtmf_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  wire logic  clk,
    input  wire logic  load,
    input  wire logic  [31:0] phase_lo,
    input  wire logic  [31:0] phase_hi,
    output sine_t      sine_lo,
    output sine_t      sine_hi
);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int DW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW    = 32 + DW;

    typedef sine_t rom_t [SINE_TABLE_DEPTH];

    function automatic rom_t build_rom();
        rom_t        t;
        logic [63:0] p;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            p    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
            t[k] = sine_q30(p[31:0]);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PW-1:0]    prod_lo;
    logic [PW-1:0]    prod_hi;
    logic [IDX_W-1:0] idx_lo_reg;
    logic [IDX_W-1:0] idx_hi_reg;
    sine_t            sine_lo_reg;
    sine_t            sine_hi_reg;

    // index = phase * depth / 2^32, always below depth
    assign prod_lo = PW'(phase_lo) * PW'(SINE_TABLE_DEPTH);
    assign prod_hi = PW'(phase_hi) * PW'(SINE_TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_lo_reg <= prod_lo[32 +: IDX_W];
            idx_hi_reg <= prod_hi[32 +: IDX_W];
        end
    end

    always_ff @(posedge clk)
    begin
        sine_lo_reg <= SINE_ROM[idx_lo_reg];
        sine_hi_reg <= SINE_ROM[idx_hi_reg];
    end

    assign sine_lo = sine_lo_reg;
    assign sine_hi = sine_hi_reg;

endmodule

`default_nettype wire

// File: rtl/dtmf_res_fifo.sv
// small result queue that decouples the pipeline from the output stall
`default_nettype none

module dtmf_res_fifo
    import dtmf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  dtmf_result_t push_data,
    input  wire logic   pop,
    output logic        head_valid,
    output dtmf_result_t head_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    dtmf_result_t     entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: bench/dtmf_tone_generator_unit_test.sv
// self-checking bench for the dtmf tone generator: predicts every sample and burst flag
module dtmf_tone_generator_unit_test;

    localparam int     TABLE_DEPTH = 1024;
    localparam int     RATE_HZ     = 48000;
    localparam longint Q30         = 64'sd1073741824;
    localparam longint HALF_PI     = 64'sd1686629713;
    localparam longint MIX_GAIN    = 64'sd16383;
    localparam int     MAX_WAIT    = 17;
    localparam int     LONG_HOLD   = 80;
    localparam int     DRAIN_WAIT  = 4;
    localparam int     CYCLE_LIMIT = 2000000;

    localparam int ROW_FREQ [4] = '{697, 770, 852, 941};
    localparam int COL_FREQ [4] = '{1209, 1336, 1477, 1633};
    localparam logic [1:0] ROW_OF_KEY [16] = '{
        2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
        2'd2, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3
    };
    localparam logic [1:0] COL_OF_KEY [16] = '{
        2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd2
    };

    typedef struct {
        logic [3:0] key;
        logic       restart;
        int         gap;
    } key_press_t;

    typedef struct {
        logic signed [15:0] pcm;
        logic               last;
    } tone_sample_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [3:0]          key = 4'd0;
    logic                restart = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    dtmf_pkg::sample_t   sample;
    logic                last_of_burst;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_burst_length = 16'd0;

    // tone model state
    logic signed [31:0]  sine_tab [TABLE_DEPTH];
    logic [31:0]         row_phase = 32'd0;
    logic [31:0]         col_phase = 32'd0;
    logic [15:0]         burst_pos = 16'd0;
    logic [15:0]         burst_len_reg = 16'd1920;

    key_press_t          key_presses [$];
    tone_sample_t        expected_tones [$];
    key_press_t          next_press;
    tone_sample_t        head_tone;

    int items_queued = 0;
    int items_sent = 0;
    int in_accepts = 0;
    int results_seen = 0;
    int results_counted = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int tx_gap = 0;
    int rx_wait = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    bit rx_idle_on = 1'b0;

    dtmf_tone_generator_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .key              (key),
        .restart          (restart),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sample           (sample),
        .last_of_burst    (last_of_burst),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_burst_length (cfg_burst_length)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // sine in q30 of a 32-bit phase, taylor series folded into the first quadrant
    function automatic logic signed [31:0] q30_sine(input logic [31:0] ph);
        logic [63:0] frac;
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        frac   = ph[30] ? (64'd1 << 30) - {34'd0, ph[29:0]} : {34'd0, ph[29:0]};
        ang    = (frac * 64'(HALF_PI)) >> 30;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'(2 * n * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > Q30)
            acc = Q30;
        if (ph[31])
            acc = -acc;
        return 32'(acc);
    endfunction

    function automatic logic [31:0] phase_step(input int hz);
        return 32'(((longint'(hz) << 32) + RATE_HZ / 2) / RATE_HZ);
    endfunction

    function automatic logic signed [31:0] sine_at(input logic [31:0] ph);
        logic [63:0] idx;
        idx = (64'(ph) * 64'(TABLE_DEPTH)) >> 32;
        return sine_tab[int'(idx)];
    endfunction

    task automatic predict_tone(input logic [3:0] k, input logic rs);
        longint       mix;
        logic [31:0]  span;
        logic [31:0]  next_pos;
        tone_sample_t t;
        if (rs)
        begin
            row_phase = 32'd0;
            col_phase = 32'd0;
            burst_pos = 16'd0;
        end
        // signed division truncates toward zero
        mix = (longint'(sine_at(row_phase)) + longint'(sine_at(col_phase))) * MIX_GAIN / Q30;
        row_phase = row_phase + phase_step(ROW_FREQ[ROW_OF_KEY[k]]);
        col_phase = col_phase + phase_step(COL_FREQ[COL_OF_KEY[k]]);
        span = (burst_len_reg == 16'd0) ? 32'd1 : {16'd0, burst_len_reg};
        next_pos = {16'd0, burst_pos} + 32'd1;
        t.last = (next_pos >= span);
        burst_pos = t.last ? 16'd0 : next_pos[15:0];
        t.pcm = mix[15:0];
        expected_tones.insert(expected_tones.size(), t);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task automatic queue_key(input logic [3:0] k, input logic rs, input int gap);
        key_press_t p;
        p.key = k;
        p.restart = rs;
        p.gap = gap;
        key_presses.insert(key_presses.size(), p);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (!(in_accepts == items_queued && expected_tones.size() == 0))
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_burst_length(input logic [15:0] value);
        int start;
        start = cfg_writes;
        @(negedge clk);
        cfg_burst_length <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (cfg_writes == start);
        cfg_valid <= 1'b0;
    endtask

    // model update and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                burst_len_reg = cfg_burst_length;
                cfg_writes++;
            end
            if (in_valid && !in_stall)
            begin
                predict_tone(key, restart);
                in_accepts++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_tones.size() == 0)
                    report_mismatch($sformatf("unexpected item: sample %0d last %0b",
                        sample, last_of_burst));
                else
                begin
                    head_tone = expected_tones.pop_front();
                    if (sample !== head_tone.pcm)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                            sample, head_tone.pcm));
                    if (last_of_burst !== head_tone.last)
                        report_mismatch($sformatf("last_of_burst %0b, expected %0b",
                            last_of_burst, head_tone.last));
                end
                results_seen++;
            end
        end
    end

    // input side: hold the item until taken, then wait out its gap
    always @(negedge clk)
    begin
        if (!(in_valid && in_accepts != items_sent))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (key_presses.size() != 0)
            begin
                next_press = key_presses.pop_front();
                key <= next_press.key;
                restart <= next_press.restart;
                in_valid <= 1'b1;
                items_sent++;
                tx_gap = next_press.gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: per-item stall draw plus an occasional long hold
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            hold_left = LONG_HOLD;
            holds_served = hold_requests;
        end
        if (results_seen != results_counted)
        begin
            results_counted = results_seen;
            rx_wait = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned sel;
        logic [15:0] blen;
        logic        busy;
        int          gap;
        for (int k = 0; k < TABLE_DEPTH; k++)
            sine_tab[k] = q30_sine(32'((64'(k) << 32) / 64'(TABLE_DEPTH)));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset burst length: first item with no restart, every key, restarts back to back
        rx_idle_on = 1'b1;
        queue_key(4'd0, 1'b0, 0);
        for (int k = 0; k < 16; k++)
            queue_key(4'(k), 1'b0, (k % 3 == 0) ? $urandom_range(0, MAX_WAIT) : 0);
        queue_key(4'd15, 1'b1, 0);
        queue_key(4'd14, 1'b1, 0);
        queue_key(4'd14, 1'b1, 2);
        queue_key(4'd1, 1'b0, 0);
        wait_idle();
        rx_idle_on = 1'b0;

        // zero acts as one, then one
        write_burst_length(16'd0);
        rx_idle_on = 1'b1;
        for (int i = 0; i < 30; i++)
            queue_key(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                $urandom_range(0, MAX_WAIT));
        wait_idle();
        write_burst_length(16'd1);
        rx_idle_on = 1'b0;
        for (int i = 0; i < 30; i++)
            queue_key(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                $urandom_range(0, MAX_WAIT));
        wait_idle();

        // burst length lowered in the middle of a burst
        write_burst_length(16'd100);
        queue_key(4'd7, 1'b1, 0);
        for (int i = 0; i < 49; i++)
            queue_key(4'($urandom_range(0, 15)), 1'b0, 0);
        wait_idle();
        write_burst_length(16'd10);
        for (int i = 0; i < 12; i++)
            queue_key(4'($urandom_range(0, 15)), 1'b0, 0);
        wait_idle();

        // longest burst length, no early flag
        write_burst_length(16'hFFFF);
        queue_key(4'($urandom_range(0, 15)), 1'b1, 0);
        for (int i = 1; i < 20; i++)
            queue_key(4'($urandom_range(0, 15)), 1'b0, 0);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                blen = 16'($urandom_range(0, 65535));
            else if (sel == 1)
                blen = 16'($urandom_range(0, 1));
            else
                blen = 16'($urandom_range(2, 16));
            // some phases keep the previous length
            if (sel != 2)
                write_burst_length(blen);
            rx_idle_on = 1'($urandom_range(0, 1));
            if (p == 3)
            begin
                // back up the result queue into the input
                rx_idle_on = 1'b0;
                hold_requests++;
            end
            busy = 1'b0;
            for (int i = 0; i < 80; i++)
            begin
                if (i % 16 == 0)
                    busy = 1'($urandom_range(0, 1));
                gap = (busy && !(p == 3 && i < 40)) ? $urandom_range(0, MAX_WAIT) : 0;
                queue_key(4'($urandom_range(0, 15)), ($urandom_range(0, 9) == 0), gap);
            end
            wait_idle();
        end

        repeat (8) @(negedge clk);
        if (expected_tones.size() != 0)
            report_mismatch($sformatf("%0d items never delivered", expected_tones.size()));
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
